FILE: rtl/msp_pkg.sv
// ============================================================================
// msp_pkg: shared types and constants for the Markov successor predictor
// Request and result structs, operation and status codes, FSM states.
// ============================================================================
package msp_pkg;

  localparam int unsigned StateEntries = 64;
  localparam int unsigned Successors   = 8;
  localparam int unsigned MaxResults   = 8;
  localparam int unsigned EntryW = $clog2(StateEntries);
  localparam int unsigned SlotW  = (Successors > 1) ? $clog2(Successors) : 1;
  localparam int unsigned SlotCntW = $clog2(Successors + 1);
  localparam int unsigned SuccAddrW = $clog2(StateEntries * Successors);
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_RECORD  = 1'b0,
    OP_PREDICT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_PREDICTION = 3'd0,
    ST_BUMPED     = 3'd1,
    ST_ADDED      = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_LIST_FULL  = 3'd4
  } status_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] curr_blk;
    logic [31:0] succ_blk;
    logic [3:0]  top_k;
  } req_t;

  typedef struct packed {
    logic [31:0] predicted_block;
    logic        has_prediction;
    logic [2:0]  status;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_TAG_RD,
    FSM_TAG_CMP,
    FSM_SUCC_RD,
    FSM_SUCC_CAP,
    FSM_UPDATE,
    FSM_CLEAR,
    FSM_SELECT,
    FSM_EMIT,
    FSM_DONE
  } fsm_e;

endpackage

FILE: rtl/markov_successor_predictor_unit.sv
// ============================================================================
// markov_successor_predictor_unit: Markov block-access predictor
// Tag table and successor table in synchronous memories, one sequencer.
// ============================================================================
// Usage:
//   Request channel (req_valid_i/req_stall_o/req_i): operation 0 records that
//   succ_blk followed curr_blk; operation 1 asks for up to top_k
//   successors in descending count order (ties in insertion order).
//   Result channel (rsp_valid_o/rsp_stall_i/rsp_o): a record gives one result;
//   a predict gives 1..8 results, the final one flagged by last.
// Timing:
//   One request at a time. The tag search reads and then compares each entry in
//   turn, stopping at the first hit; the successor row is then read one slot
//   per cycle. A record finishes with at most one write (a new entry instead
//   clears its row). A predict passes through a selection state and an emit
//   state for each result.
//   The result register lets the next request be accepted while the last
//   result waits.
// Reset: the valid bits clear at once; memory contents need no clearing.
// A stalled result simply holds; the sequencer waits for the register.
module markov_successor_predictor_unit
  import msp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o
);

  // memories
  logic [31:0] tag_mem [StateEntries];
  logic [31:0] sid_mem [StateEntries*Successors];
  logic [31:0] scnt_mem [StateEntries*Successors];
  logic [StateEntries-1:0] valid_q, valid_d;

  fsm_e state_q, state_d;
  req_t req_q;
  logic [EntryW:0] idx_q, idx_d;           // scan counter
  logic [EntryW-1:0] ent_q, ent_d;
  logic hit_q, hit_d;
  logic free_found_q, free_found_d;
  logic [EntryW-1:0] free_q, free_d;
  logic [SlotCntW-1:0] slot_q, slot_d;
  logic [31:0] tag_rd_q, sid_rd_q, cnt_rd_q;
  logic [31:0] row_id_q [Successors];
  logic [31:0] row_cnt_q [Successors];
  logic [Successors-1:0] taken_q, taken_d;
  logic [SlotW-1:0] best_q, best_d;
  logic [3:0] want_q, want_d;
  logic [3:0] nout_q, nout_d;

  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;
  logic rsp_load;

  logic accept;
  logic rsp_free;
  assign rsp_free = !rsp_valid_q || !rsp_stall_i;
  assign req_stall_o = (state_q != FSM_IDLE);
  assign accept = req_valid_i && !req_stall_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  // memory control
  logic tag_we;
  logic [EntryW-1:0] tag_rd_addr;
  logic succ_we;
  logic [SuccAddrW-1:0] succ_waddr, succ_raddr;
  logic [31:0] succ_wid, succ_wcnt;

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[ent_q] <= req_q.curr_blk;
    tag_rd_q <= tag_mem[tag_rd_addr];
    if (succ_we) begin
      sid_mem[succ_waddr]  <= succ_wid;
      scnt_mem[succ_waddr] <= succ_wcnt;
    end
    sid_rd_q <= sid_mem[succ_raddr];
    cnt_rd_q <= scnt_mem[succ_raddr];
  end

  // row capture: read data lands in the row slot named by the delayed slot index
  logic [SlotCntW-1:0] cap_slot_q;
  logic cap_en_q;
  always_ff @(posedge clk_i) begin
    if (cap_en_q) begin
      row_id_q[cap_slot_q[SlotW-1:0]]  <= sid_rd_q;
      row_cnt_q[cap_slot_q[SlotW-1:0]] <= cnt_rd_q;
    end
  end

  // combinational row analysis
  logic              m_found;
  logic [SlotW-1:0]  m_slot;
  logic              f_found;
  logic [SlotW-1:0]  f_slot;
  logic [SlotCntW-1:0] stored;
  always_comb begin
    m_found = 1'b0; m_slot = '0; f_found = 1'b0; f_slot = '0; stored = '0;
    for (int s = 0; s < Successors; s++) begin
      if (row_cnt_q[s] != 32'd0) begin
        stored = stored + SlotCntW'(1);
        if (!m_found && row_id_q[s] == req_q.succ_blk) begin
          m_found = 1'b1; m_slot = SlotW'(s);
        end
      end else if (!f_found) begin
        f_found = 1'b1; f_slot = SlotW'(s);
      end
    end
  end

  // best untaken slot (strictly greater keeps insertion order on ties)
  logic             b_found;
  logic [SlotW-1:0] b_slot;
  always_comb begin
    b_found = 1'b0; b_slot = '0;
    for (int s = 0; s < Successors; s++) begin
      if (row_cnt_q[s] != 32'd0 && !taken_q[s]) begin
        if (!b_found || row_cnt_q[s] > row_cnt_q[b_slot]) begin
          b_found = 1'b1; b_slot = SlotW'(s);
        end
      end
    end
  end

  // next state and datapath
  always_comb begin
    state_d = state_q; idx_d = idx_q; ent_d = ent_q; hit_d = hit_q;
    free_found_d = free_found_q; free_d = free_q; slot_d = slot_q;
    taken_d = taken_q; best_d = best_q; want_d = want_q; nout_d = nout_q;
    valid_d = valid_q;
    tag_rd_addr = idx_q[EntryW-1:0];
    succ_raddr = {ent_q, slot_q[SlotW-1:0]};
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_TAG_RD; idx_d = '0; hit_d = 1'b0; free_found_d = 1'b0;
        end
      end
      FSM_TAG_RD: begin
        state_d = FSM_TAG_CMP;
      end
      FSM_TAG_CMP: begin
        // compare word read for idx_q
        if (valid_q[idx_q[EntryW-1:0]] && tag_rd_q == req_q.curr_blk) begin
          hit_d = 1'b1; ent_d = idx_q[EntryW-1:0];
        end else if (!valid_q[idx_q[EntryW-1:0]] && !free_found_q) begin
          free_found_d = 1'b1; free_d = idx_q[EntryW-1:0];
        end
        if ((valid_q[idx_q[EntryW-1:0]] && tag_rd_q == req_q.curr_blk) ||
            idx_q == (EntryW+1)'(StateEntries - 1)) begin
          state_d = FSM_SUCC_RD; slot_d = '0;
        end else begin
          idx_d = idx_q + 1'b1; state_d = FSM_TAG_RD;
        end
      end
      FSM_SUCC_RD: begin
        if (!hit_q) begin
          if (req_q.operation == OP_PREDICT) begin
            state_d = FSM_DONE;
          end else if (free_found_q) begin
            ent_d = free_q; slot_d = '0; state_d = FSM_CLEAR;
            valid_d[free_q] = 1'b1;
          end else begin
            state_d = FSM_DONE;
          end
        end else begin
          state_d = FSM_SUCC_CAP;
          slot_d = slot_q + 1'b1;
        end
      end
      FSM_SUCC_CAP: begin
        if (slot_q == SlotCntW'(Successors)) begin
          state_d = FSM_UPDATE;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      FSM_UPDATE: begin
        // decide once no row capture is pending
        if (!cap_en_q) begin
          if (req_q.operation == OP_RECORD) begin
            state_d = FSM_DONE;
          end else begin
            taken_d = '0; nout_d = '0;
            want_d = (req_q.top_k < 4'(stored)) ? req_q.top_k : 4'(stored);
            if (want_d > 4'(MaxResults)) want_d = 4'(MaxResults);
            state_d = (want_d == 4'd0) ? FSM_DONE : FSM_SELECT;
          end
        end
      end
      FSM_CLEAR: begin
        if (slot_q == SlotCntW'(Successors - 1)) state_d = FSM_DONE;
        else slot_d = slot_q + 1'b1;
      end
      FSM_SELECT: begin
        best_d = b_slot; taken_d[b_slot] = 1'b1; state_d = FSM_EMIT;
      end
      FSM_EMIT: begin
        if (rsp_free) begin
          nout_d = nout_q + 1'b1;
          state_d = (nout_q + 1'b1 == want_q) ? FSM_IDLE : FSM_SELECT;
        end
      end
      FSM_DONE: begin
        if (rsp_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // record outcome
  status_e rec_status;
  always_comb begin
    if (!hit_q) rec_status = free_found_q ? ST_ADDED : ST_TABLE_FULL;
    else if (m_found) rec_status = ST_BUMPED;
    else if (f_found) rec_status = ST_ADDED;
    else rec_status = ST_LIST_FULL;
  end

  // outputs: memory writes and result loads
  always_comb begin
    tag_we = 1'b0; succ_we = 1'b0;
    succ_waddr = {ent_q, slot_q[SlotW-1:0]};
    succ_wid = req_q.succ_blk; succ_wcnt = 32'd1;
    rsp_load = 1'b0;
    rsp_d = '0;
    rsp_d.last = 1'b1;
    rsp_d.status = ST_PREDICTION;
    unique case (state_q)
      FSM_CLEAR: begin
        tag_we = (slot_q == '0);
        succ_we = 1'b1;
        succ_wcnt = (slot_q == '0) ? 32'd1 : 32'd0;
      end
      FSM_UPDATE: begin
        if (!cap_en_q && req_q.operation == OP_RECORD) begin
          if (m_found) begin
            succ_we = 1'b1;
            succ_waddr = {ent_q, m_slot};
            succ_wcnt = (row_cnt_q[m_slot] == CountMax) ? CountMax
                                                        : row_cnt_q[m_slot] + 32'd1;
          end else if (f_found) begin
            succ_we = 1'b1;
            succ_waddr = {ent_q, f_slot};
          end
        end
      end
      FSM_DONE: begin
        rsp_load = rsp_free;
        rsp_d.status = (req_q.operation == OP_RECORD) ? rec_status : ST_PREDICTION;
      end
      FSM_EMIT: begin
        rsp_load = rsp_free;
        rsp_d.predicted_block = row_id_q[best_q];
        rsp_d.has_prediction = 1'b1;
        rsp_d.last = (nout_q + 1'b1 == want_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      valid_q <= '0;
      rsp_valid_q <= 1'b0;
      cap_en_q <= 1'b0;
      hit_q <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      hit_q <= hit_d;
      free_found_q <= free_found_d;
      cap_en_q <= (state_q == FSM_SUCC_RD && hit_q) ||
                  (state_q == FSM_SUCC_CAP && slot_q != SlotCntW'(Successors));
      if (rsp_load) rsp_valid_q <= 1'b1;
      else if (!rsp_stall_i) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    idx_q <= idx_d; ent_q <= ent_d; free_q <= free_d; slot_q <= slot_d;
    taken_q <= taken_d; best_q <= best_d; want_q <= want_d; nout_q <= nout_d;
    cap_slot_q <= slot_q;
    if (rsp_load) rsp_q <= rsp_d;
  end

`ifndef ASSERT_OFF
  // a new request is never taken mid-sequence
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == FSM_IDLE) else $error("accept outside idle");
  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed under stall");
  // predictions always carry the prediction status
  a_pred_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.has_prediction |-> rsp_o.status == ST_PREDICTION)
    else $error("bad status on prediction");
`endif

endmodule
